/* rtl/dsw_pkg.sv */
// Package for the dice sum ways counter: constants, microcode ROM and modular arithmetic.
package dsw_pkg;

  localparam int WAY_W      = 30;
  localparam int DICE_W     = 6;
  localparam int FACE_W     = 6;
  localparam int TGT_W      = 11;
  localparam int MAX_DICE   = 32;
  localparam int MAX_FACES  = 32;
  localparam int MAX_TARGET = 1024;
  localparam logic [WAY_W:0] WAY_MOD = 31'd1000000007;

  localparam int UPC_W = 4;

  typedef enum logic [3:0] {
    A_NONE,
    A_LOAD,
    A_CLR,
    A_WIN0,
    A_READ,
    A_ADD,
    A_SUB,
    A_SWAP,
    A_OUT
  } act_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_REJECT,
    C_T_MORE,
    C_NO_DICE,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    act_t             act;
    cond_t            cond;
    logic [UPC_W-1:0] jmp;
    logic             addr_tgt;
  } ctl_t;

  localparam logic [UPC_W-1:0] S_IDLE  = 4'd0;
  localparam logic [UPC_W-1:0] S_CHECK = 4'd1;
  localparam logic [UPC_W-1:0] S_CLR   = 4'd2;
  localparam logic [UPC_W-1:0] S_DIE   = 4'd3;
  localparam logic [UPC_W-1:0] S_READ  = 4'd4;
  localparam logic [UPC_W-1:0] S_ADD   = 4'd5;
  localparam logic [UPC_W-1:0] S_SUB   = 4'd6;
  localparam logic [UPC_W-1:0] S_SWAP  = 4'd7;
  localparam logic [UPC_W-1:0] S_FETCH = 4'd8;
  localparam logic [UPC_W-1:0] S_OUT   = 4'd9;
  localparam logic [UPC_W-1:0] S_WAIT  = 4'd10;

  function automatic ctl_t rom(input logic [UPC_W-1:0] upc);
    ctl_t c;
    c = '{act: A_NONE, cond: C_ALWAYS, jmp: S_IDLE, addr_tgt: 1'b1};
    case (upc)
      S_IDLE:  c = '{act: A_LOAD, cond: C_NO_INPUT, jmp: S_IDLE,  addr_tgt: 1'b1};
      S_CHECK: c = '{act: A_NONE, cond: C_REJECT,   jmp: S_FETCH, addr_tgt: 1'b1};
      S_CLR:   c = '{act: A_CLR,  cond: C_T_MORE,   jmp: S_CLR,   addr_tgt: 1'b0};
      S_DIE:   c = '{act: A_WIN0, cond: C_NO_DICE,  jmp: S_FETCH, addr_tgt: 1'b1};
      S_READ:  c = '{act: A_READ, cond: C_NEVER,    jmp: S_IDLE,  addr_tgt: 1'b0};
      S_ADD:   c = '{act: A_ADD,  cond: C_NEVER,    jmp: S_IDLE,  addr_tgt: 1'b0};
      S_SUB:   c = '{act: A_SUB,  cond: C_T_MORE,   jmp: S_READ,  addr_tgt: 1'b0};
      S_SWAP:  c = '{act: A_SWAP, cond: C_ALWAYS,   jmp: S_DIE,   addr_tgt: 1'b1};
      S_FETCH: c = '{act: A_NONE, cond: C_NEVER,    jmp: S_IDLE,  addr_tgt: 1'b1};
      S_OUT:   c = '{act: A_OUT,  cond: C_OUT_FREE, jmp: S_IDLE,  addr_tgt: 1'b1};
      S_WAIT:  c = '{act: A_NONE, cond: C_ALWAYS,   jmp: S_OUT,   addr_tgt: 1'b1};
      default: c = '{act: A_NONE, cond: C_ALWAYS,   jmp: S_IDLE,  addr_tgt: 1'b1};
    endcase
    return c;
  endfunction

  function automatic logic [WAY_W-1:0] mod_add(input logic [WAY_W-1:0] a,
                                                input logic [WAY_W-1:0] b);
    logic [WAY_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= WAY_MOD) begin
      s = s - WAY_MOD;
    end
    return s[WAY_W-1:0];
  endfunction

  function automatic logic [WAY_W-1:0] mod_sub(input logic [WAY_W-1:0] a,
                                                input logic [WAY_W-1:0] b);
    logic [WAY_W:0] s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + (WAY_MOD - {1'b0, b});
    end
    return s[WAY_W-1:0];
  endfunction

endpackage

/* rtl/dice_sum_ways_counter.sv */
// Dice sum ways counter: microcoded sequencer over two ping-pong row memories.
//
// Input channel (in_valid/in_stall) carries one query: dice_count, face_count
// and target_sum. Output channel (out_valid/out_stall) carries way_count, the
// number of ordered rolls reaching target_sum modulo 1000000007.
// One query is worked at a time; in_stall is low only while the sequencer
// waits in its idle step.
// The sequencer clears the first row up to target_sum, then for each die
// runs the three-step read/add/subtract loop per row entry and swaps the
// rows; both row reads come through the registered read ports of the
// previous row. The next query can transfer in the idle step that follows
// the result register load. Out-of-range queries skip the rows and return
// zero.
// The result sits in an output register; the next query is taken while it
// waits. If the receiver stalls, out_way_count holds until transferred, and
// a following result waits in the sequencer until the register frees.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// out_valid. Row memories are not cleared; each query rewrites what it reads.
module dice_sum_ways_counter #(
  parameter int MAX_TARGET = dsw_pkg::MAX_TARGET
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [dsw_pkg::DICE_W-1:0] in_dice_count,
  input  logic [dsw_pkg::FACE_W-1:0] in_face_count,
  input  logic [dsw_pkg::TGT_W-1:0]  in_target_sum,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [dsw_pkg::WAY_W-1:0]  out_way_count
);

  localparam int DEPTH  = MAX_TARGET + 1;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int WAY_W  = dsw_pkg::WAY_W;

  logic [dsw_pkg::UPC_W-1:0]  upc_r, upc_nxt;
  dsw_pkg::ctl_t              ctl;
  logic                       jump;

  logic [ADDR_W-1:0]          t_r, t_nxt;
  logic [ADDR_W-1:0]          target_r, target_nxt;
  logic [dsw_pkg::DICE_W-1:0] dice_r, dice_nxt;
  logic [dsw_pkg::FACE_W-1:0] faces_r, faces_nxt;
  logic                       reject_r, reject_nxt;
  logic                       bank_r, bank_nxt;
  logic [WAY_W-1:0]           window_r, window_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [WAY_W-1:0]           out_way_r, out_way_nxt;

  logic                       in_xfer;
  logic                       in_reject;
  logic                       t_last;
  logic                       t_ge_faces;
  logic [ADDR_W-1:0]          t_step;

  logic [ADDR_W-1:0]          ra0, ra1, wa;
  logic [WAY_W-1:0]           wd;
  logic                       we, wsel;
  logic [WAY_W-1:0]           mem_a [DEPTH];
  logic [WAY_W-1:0]           mem_b [DEPTH];
  logic [WAY_W-1:0]           rd0_a_r, rd1_a_r, rd0_b_r, rd1_b_r;
  logic [WAY_W-1:0]           rd0, rd1;

  assign ctl        = dsw_pkg::rom(upc_r);
  assign in_stall   = (ctl.act != dsw_pkg::A_LOAD);
  assign in_xfer    = in_valid && !in_stall;
  assign in_reject  = (32'(in_dice_count) > dsw_pkg::MAX_DICE) ||
                      (32'(in_face_count) > dsw_pkg::MAX_FACES) ||
                      (32'(in_target_sum) > MAX_TARGET);
  assign t_last     = (t_r == target_r);
  assign t_step     = t_last ? '0 : t_r + ADDR_W'(1);
  assign t_ge_faces = (32'(t_r) >= 32'(faces_r));

  assign ra0  = ctl.addr_tgt ? target_r : t_r;
  assign ra1  = t_ge_faces ? t_r - ADDR_W'(faces_r) : '0;
  assign wa   = t_r;
  assign we   = (ctl.act == dsw_pkg::A_CLR) || (ctl.act == dsw_pkg::A_READ);
  assign wsel = (ctl.act == dsw_pkg::A_CLR) ? bank_r : !bank_r;
  assign wd   = (ctl.act == dsw_pkg::A_CLR) ? ((t_r == '0) ? WAY_W'(1) : '0) : window_r;
  assign rd0  = bank_r ? rd0_b_r : rd0_a_r;
  assign rd1  = bank_r ? rd1_b_r : rd1_a_r;

  always_ff @(posedge clk) begin
    if (we && !wsel) begin
      mem_a[wa] <= wd;
    end
    rd0_a_r <= mem_a[ra0];
    rd1_a_r <= mem_a[ra1];
  end

  always_ff @(posedge clk) begin
    if (we && wsel) begin
      mem_b[wa] <= wd;
    end
    rd0_b_r <= mem_b[ra0];
    rd1_b_r <= mem_b[ra1];
  end

  always_comb begin
    case (ctl.cond)
      dsw_pkg::C_NEVER:    jump = 1'b0;
      dsw_pkg::C_ALWAYS:   jump = 1'b1;
      dsw_pkg::C_NO_INPUT: jump = !in_valid;
      dsw_pkg::C_REJECT:   jump = reject_r;
      dsw_pkg::C_T_MORE:   jump = !t_last;
      dsw_pkg::C_NO_DICE:  jump = (dice_r == '0);
      dsw_pkg::C_OUT_FREE: jump = !out_valid_r;
      default:             jump = 1'b0;
    endcase
    upc_nxt = jump ? ctl.jmp : upc_r + dsw_pkg::UPC_W'(1);
  end

  always_comb begin
    t_nxt         = t_r;
    target_nxt    = target_r;
    dice_nxt      = dice_r;
    faces_nxt     = faces_r;
    reject_nxt    = reject_r;
    bank_nxt      = bank_r;
    window_nxt    = window_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_way_nxt   = out_way_r;
    case (ctl.act)
      dsw_pkg::A_LOAD: begin
        if (in_xfer) begin
          t_nxt      = '0;
          dice_nxt   = in_dice_count;
          faces_nxt  = in_face_count;
          reject_nxt = in_reject;
          target_nxt = in_reject ? '0 : ADDR_W'(in_target_sum);
        end
      end
      dsw_pkg::A_CLR: t_nxt = t_step;
      dsw_pkg::A_WIN0: begin
        window_nxt = '0;
        t_nxt      = '0;
      end
      dsw_pkg::A_READ: ;
      dsw_pkg::A_ADD:  window_nxt = dsw_pkg::mod_add(window_r, rd0);
      dsw_pkg::A_SUB: begin
        if (t_ge_faces) begin
          window_nxt = dsw_pkg::mod_sub(window_r, rd1);
        end
        t_nxt = t_step;
      end
      dsw_pkg::A_SWAP: begin
        bank_nxt = !bank_r;
        dice_nxt = dice_r - dsw_pkg::DICE_W'(1);
      end
      dsw_pkg::A_OUT: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          out_way_nxt   = reject_r ? '0 : rd0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= dsw_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      bank_r      <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      out_valid_r <= out_valid_nxt;
      bank_r      <= bank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r       <= t_nxt;
    target_r  <= target_nxt;
    dice_r    <= dice_nxt;
    faces_r   <= faces_nxt;
    reject_r  <= reject_nxt;
    window_r  <= window_nxt;
    out_way_r <= out_way_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_way_count = out_way_r;

endmodule

/* rtl/dsw_checker.sv */
// Port-level checker for the dice sum ways counter, bound to the top level.
module dsw_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [dsw_pkg::WAY_W-1:0] out_way_count
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while previous query still in work");

  a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_way_count} < dsw_pkg::WAY_MOD))
    else $error("way_count not reduced");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_way_count))
    else $error("stalled result changed");

endmodule

bind dice_sum_ways_counter dsw_checker u_dsw_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_way_count (out_way_count)
);

/* sim/tb.sv */
// Self-checking testbench for the dice sum ways counter: directed and random roll queries.
module tb;

  typedef struct packed {
    logic [dsw_pkg::DICE_W-1:0] dice;
    logic [dsw_pkg::FACE_W-1:0] faces;
    logic [dsw_pkg::TGT_W-1:0]  target;
  } roll_query_t;

  typedef struct {
    roll_query_t                query;
    logic [dsw_pkg::WAY_W-1:0]  ways;
  } ways_due_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [dsw_pkg::DICE_W-1:0] in_dice_count = '0;
  logic [dsw_pkg::FACE_W-1:0] in_face_count = '0;
  logic [dsw_pkg::TGT_W-1:0]  in_target_sum = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [dsw_pkg::WAY_W-1:0]  out_way_count;

  ways_due_t   ways_due[$];
  logic [dsw_pkg::WAY_W-1:0] prev_row [0:dsw_pkg::MAX_TARGET];
  logic [dsw_pkg::WAY_W-1:0] next_row [0:dsw_pkg::MAX_TARGET];
  bit          idle_on = 1'b1;
  int          fail_count = 0;
  int          sent_count = 0;
  int          checked_count = 0;

  dice_sum_ways_counter DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_dice_count (in_dice_count),
    .in_face_count (in_face_count),
    .in_target_sum (in_target_sum),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_way_count (out_way_count)
  );

  always #5 clk = ~clk;

  // Ordered rolls reaching the target, mod 1e9+7, via sliding window over two rows.
  function automatic logic [dsw_pkg::WAY_W-1:0] count_rolls(input roll_query_t q);
    longint unsigned window;
    longint unsigned modulus;
    int d;
    int t;
    modulus = longint'(dsw_pkg::WAY_MOD);
    if (q.dice > dsw_pkg::MAX_DICE || q.faces > dsw_pkg::MAX_FACES ||
        q.target > dsw_pkg::MAX_TARGET) begin
      return '0;
    end
    for (t = 0; t <= int'(q.target); t++) begin
      prev_row[t] = (t == 0) ? 30'd1 : 30'd0;
    end
    for (d = 0; d < int'(q.dice); d++) begin
      window = 0;
      for (t = 0; t <= int'(q.target); t++) begin
        next_row[t] = window[dsw_pkg::WAY_W-1:0];
        window = (window + prev_row[t]) % modulus;
        if (t >= int'(q.faces)) begin
          window = (window + modulus - prev_row[t - int'(q.faces)]) % modulus;
        end
      end
      for (t = 0; t <= int'(q.target); t++) begin
        prev_row[t] = next_row[t];
      end
    end
    return prev_row[q.target];
  endfunction

  function automatic int pick_gap();
    int roll;
    if (!idle_on) begin
      return 0;
    end
    roll = $urandom_range(99);
    if (roll < 50) return 0;
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 94) return $urandom_range(4, 20);
    return $urandom_range(100, 3000);
  endfunction

  function automatic roll_query_t random_query(input int tgt_cap);
    roll_query_t q;
    int roll;
    roll = $urandom_range(99);
    q.dice   = dsw_pkg::DICE_W'($urandom_range(dsw_pkg::MAX_DICE));
    q.faces  = dsw_pkg::FACE_W'($urandom_range(1, dsw_pkg::MAX_FACES));
    q.target = dsw_pkg::TGT_W'($urandom_range(tgt_cap));
    if (roll < 4) q.dice = dsw_pkg::DICE_W'($urandom_range(dsw_pkg::MAX_DICE + 1, 63));
    else if (roll < 8) q.faces = dsw_pkg::FACE_W'($urandom_range(dsw_pkg::MAX_FACES + 1, 63));
    else if (roll < 12) q.target = dsw_pkg::TGT_W'($urandom_range(dsw_pkg::MAX_TARGET + 1, 2047));
    else if (roll < 15) q.faces = '0;
    else if (roll < 18) q.dice = '0;
    return q;
  endfunction

  task automatic send_query(input roll_query_t q);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_dice_count <= q.dice;
    in_face_count <= q.faces;
    in_target_sum <= q.target;
    do @(posedge clk); while (in_stall);
    ways_due.push_back('{query: q, ways: count_rolls(q)});
    sent_count++;
  endtask

  task automatic send_fields(input int dice, input int faces, input int target);
    roll_query_t q;
    q.dice   = dsw_pkg::DICE_W'(dice);
    q.faces  = dsw_pkg::FACE_W'(faces);
    q.target = dsw_pkg::TGT_W'(target);
    send_query(q);
  endtask

  task automatic test_zero_dice();
    send_fields(0, 6, 0);
    send_fields(0, 6, 5);
    send_fields(0, 0, 0);
    send_fields(0, 0, 3);
  endtask

  task automatic test_edge_sizes();
    send_fields(3, 6, 0);
    send_fields(2, 0, 4);
    send_fields(32, 1, 32);
    send_fields(5, 32, 160);
    send_fields(1, 32, 1023);
    send_fields(32, 32, 1024);
    send_fields(32, 32, 32);
  endtask

  task automatic test_rejected_queries();
    send_fields(33, 6, 10);
    send_fields(63, 63, 2047);
    send_fields(5, 33, 10);
    send_fields(5, 6, 1025);
    send_fields(0, 0, 2047);
    send_fields(32, 32, 1025);
  endtask

  task automatic test_random_small();
    repeat (70) send_query(random_query(($urandom_range(99) < 80) ? 40 : 150));
  endtask

  task automatic test_random_no_idle();
    idle_on = 1'b0;
    repeat (20) send_query(random_query(40));
    idle_on = 1'b1;
  endtask

  task automatic test_random_wide();
    roll_query_t q;
    repeat (4) begin
      q.dice   = dsw_pkg::DICE_W'($urandom_range(1, 3));
      q.faces  = dsw_pkg::FACE_W'($urandom_range(1, dsw_pkg::MAX_FACES));
      q.target = dsw_pkg::TGT_W'($urandom_range(200, dsw_pkg::MAX_TARGET));
      send_query(q);
    end
  endtask

  // result side back-pressure
  initial begin
    int run;
    int len;
    forever begin
      run = $urandom_range(1, 8);
      len = pick_gap();
      repeat (run) @(posedge clk);
      if (len > 0) begin
        out_stall <= 1'b1;
        repeat (len) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_ways
    ways_due_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (ways_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("%0t: unexpected transfer, way_count %0d", $time, out_way_count);
        end
      end else begin
        due = ways_due.pop_front();
        checked_count++;
        if (out_way_count !== due.ways) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: dice %0d faces %0d target %0d: expected %0d, got %0d", $time,
                     due.query.dice, due.query.faces, due.query.target, due.ways,
                     out_way_count);
          end
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_dice();
    test_edge_sizes();
    test_rejected_queries();
    test_random_small();
    test_random_no_idle();
    test_random_wide();
    in_valid <= 1'b0;
    while (ways_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("%0d queries sent, %0d results checked, %0d failures", sent_count,
             checked_count, fail_count);
    $display("covered zero dice, zero faces, rejected sizes, the full-size roll and random stalls");
    if (fail_count == 0) begin
      $display("dice_sum_ways_counter verification clean");
    end else begin
      $display("dice_sum_ways_counter verification failed");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("timeout with %0d results outstanding", ways_due.size());
    $display("dice_sum_ways_counter verification failed");
    $finish;
  end

endmodule
